>>> design/dge_pkg.sv
// Package with the constants, types, exp table and fixed-point helpers of the evaluator.
`default_nettype none
package dge_pkg;

  localparam int FRAC_BITS       = 16;
  localparam int EXP_TABLE_DEPTH = 256;
  localparam int TAB_FRAC        = 30;
  localparam int EXP_SPAN        = 16;
  localparam int SPAN_LOG        = $clog2(EXP_SPAN);
  localparam int DEN_W           = FRAC_BITS + SPAN_LOG;
  localparam int IDX_W           = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int PEAK_LAT        = 9;

  localparam logic [2:0] OP_FULL   = 3'd0;
  localparam logic [2:0] OP_PEAK1  = 3'd1;
  localparam logic [2:0] OP_PEAK2  = 3'd2;
  localparam logic [2:0] OP_DERIV1 = 3'd3;
  localparam logic [2:0] OP_DERIV2 = 3'd4;

  localparam logic [2:0] REG_AMP1 = 3'd0;
  localparam logic [2:0] REG_WID1 = 3'd1;
  localparam logic [2:0] REG_CEN1 = 3'd2;
  localparam logic [2:0] REG_AMP2 = 3'd3;
  localparam logic [2:0] REG_WID2 = 3'd4;
  localparam logic [2:0] REG_CEN2 = 3'd5;
  localparam logic [2:0] REG_OFFS = 3'd6;

  // Taylor terms of the table step factor exp(-EXP_SPAN/EXP_TABLE_DEPTH) in Q30.
  localparam logic [63:0] EXP_ONE  = 64'd1 << TAB_FRAC;
  localparam logic [63:0] EXP_DIV  = 64'(EXP_TABLE_DEPTH);
  localparam logic [63:0] EXP_MUL  = 64'(EXP_SPAN);
  localparam logic [63:0] EXP_T1   = (EXP_ONE * EXP_MUL) / (EXP_DIV * 64'd1);
  localparam logic [63:0] EXP_T2   = (EXP_T1 * EXP_MUL) / (EXP_DIV * 64'd2);
  localparam logic [63:0] EXP_T3   = (EXP_T2 * EXP_MUL) / (EXP_DIV * 64'd3);
  localparam logic [63:0] EXP_T4   = (EXP_T3 * EXP_MUL) / (EXP_DIV * 64'd4);
  localparam logic [63:0] EXP_T5   = (EXP_T4 * EXP_MUL) / (EXP_DIV * 64'd5);
  localparam logic [63:0] EXP_T6   = (EXP_T5 * EXP_MUL) / (EXP_DIV * 64'd6);
  localparam logic [63:0] EXP_T7   = (EXP_T6 * EXP_MUL) / (EXP_DIV * 64'd7);
  localparam logic [63:0] EXP_T8   = (EXP_T7 * EXP_MUL) / (EXP_DIV * 64'd8);
  localparam logic [63:0] EXP_T9   = (EXP_T8 * EXP_MUL) / (EXP_DIV * 64'd9);
  localparam logic [63:0] EXP_T10  = (EXP_T9 * EXP_MUL) / (EXP_DIV * 64'd10);
  localparam logic [63:0] EXP_T11  = (EXP_T10 * EXP_MUL) / (EXP_DIV * 64'd11);
  localparam logic [63:0] EXP_T12  = (EXP_T11 * EXP_MUL) / (EXP_DIV * 64'd12);
  localparam logic [63:0] EXP_T13  = (EXP_T12 * EXP_MUL) / (EXP_DIV * 64'd13);
  localparam logic [63:0] EXP_T14  = (EXP_T13 * EXP_MUL) / (EXP_DIV * 64'd14);
  localparam logic [63:0] EXP_STEP = EXP_ONE + EXP_T2 + EXP_T4 + EXP_T6 + EXP_T8 + EXP_T10
                                     + EXP_T12 + EXP_T14
                                     - (EXP_T1 + EXP_T3 + EXP_T5 + EXP_T7 + EXP_T9 + EXP_T11
                                        + EXP_T13);

  typedef logic [TAB_FRAC:0] exp_tab_t [EXP_TABLE_DEPTH + 1];

  typedef struct packed {
    logic signed [31:0] v;
    logic               f;
  } qres_t;

  typedef struct packed {
    logic signed [31:0] g;
    logic signed [31:0] d1;
    logic signed [31:0] d2;
    logic               fg;
    logic               f1;
    logic               f2;
  } peak_res_t;

  function automatic exp_tab_t build_exp_tab();
    exp_tab_t    tab;
    logic [63:0] prod;
    tab[0] = (TAB_FRAC + 1)'(64'd1 << TAB_FRAC);
    for (int n = 1; n <= EXP_TABLE_DEPTH; n++) begin
      prod = 64'(tab[n-1]) * EXP_STEP + (64'd1 << (TAB_FRAC - 1));
      tab[n] = prod[TAB_FRAC +: TAB_FRAC + 1];
    end
    return tab;
  endfunction

  localparam exp_tab_t EXP_TAB = build_exp_tab();

  function automatic qres_t sat32(logic signed [63:0] v);
    qres_t res;
    res.f = 1'b0;
    if (v > 64'sd2147483647) begin
      res.v = 32'sh7fffffff;
      res.f = 1'b1;
    end else if (v < -64'sd2147483648) begin
      res.v = 32'sh80000000;
      res.f = 1'b1;
    end else begin
      res.v = v[31:0];
    end
    return res;
  endfunction

  function automatic qres_t qmul(logic signed [31:0] a, logic signed [31:0] b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + (64'sd1 <<< (FRAC_BITS - 1));
    return sat32(p >>> FRAC_BITS);
  endfunction

endpackage
`default_nettype wire

>>> design/dge_if.sv
// Stream interfaces for the sample input beat and the result output beat.
`default_nettype none
interface dge_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample_position;
  logic [2:0]         operation;
  modport source (output valid, output sample_position, output operation, input ready);
  modport sink (input valid, input sample_position, input operation, output ready);
endinterface

interface dge_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic               saturated;
  modport source (output valid, output result_value, output saturated, input ready);
  modport sink (input valid, input result_value, input saturated, output ready);
endinterface
`default_nettype wire

>>> design/dge_peak.sv
// Pipeline for one Gaussian peak: value, first and second derivative terms with flags.
`default_nettype none
module dge_peak (
  input  wire logic                clk_i,
  input  wire logic                en_i,
  input  wire logic signed [31:0]  x_i,
  input  wire logic signed [31:0]  amp_i,
  input  wire logic signed [31:0]  wid_i,
  input  wire logic signed [31:0]  cen_i,
  output dge_pkg::peak_res_t       res_o
);
  import dge_pkg::*;

  qres_t s1_d_q, s1_ab_q;
  qres_t s2_dd_w;
  logic signed [31:0] s2_d_q, s2_dd_q, s2_ab_q;
  logic s2_fb_q, s2_fab_q;
  qres_t s3_t_w;
  logic signed [31:0] s3_d_q, s3_t_q, s3_ab_q;
  logic s3_fb_q, s3_fab_q;
  logic [DEN_W+IDX_W-1:0] s4_p_w;
  logic [IDX_W-1:0] s4_idx_q;
  logic [DEN_W-1:0] s4_fr_q;
  logic s4_neg_q, s4_big_q, s4_fb_q, s4_fab_q;
  logic signed [31:0] s4_d_q, s4_t_q, s4_ab_q;
  logic [TAB_FRAC:0] s5_t0_q, s5_t1_q;
  logic [DEN_W-1:0] s5_fr_q;
  logic s5_neg_q, s5_big_q, s5_fb_q, s5_fab_q;
  logic signed [31:0] s5_d_q, s5_t_q, s5_ab_q;
  logic [TAB_FRAC+DEN_W:0] s6_prod_w;
  logic [TAB_FRAC:0] s6_v_w;
  logic [31:0] s6_rnd_w;
  logic signed [31:0] s6_e_q, s6_d_q, s6_t_q, s6_ab_q;
  logic s6_fb_q, s6_fab_q;
  qres_t s7_g_w, s7_p_w, s7_abe_w;
  logic signed [31:0] s7_g_q, s7_p_q, s7_abe_q, s7_e_q, s7_t_q;
  logic s7_fg_q, s7_f1_q, s7_f2_q;
  qres_t s8_q_w, s8_w_w;
  logic signed [31:0] s8_g_q, s8_q_q, s8_w_q, s8_abe_q;
  logic s8_fg_q, s8_f1_q, s8_f2_q;
  qres_t s9_d1_w, s9_d2_w;

  assign s2_dd_w   = qmul(s1_d_q.v, s1_d_q.v);
  assign s3_t_w    = qmul(wid_i, s2_dd_q);
  assign s4_p_w    = (DEN_W+IDX_W)'(s3_t_q[DEN_W-1:0]) * (DEN_W+IDX_W)'(EXP_TABLE_DEPTH);
  assign s6_prod_w = (TAB_FRAC+DEN_W+1)'(s5_t0_q - s5_t1_q) * (TAB_FRAC+DEN_W+1)'(s5_fr_q);
  assign s6_v_w    = s5_t0_q - s6_prod_w[DEN_W +: TAB_FRAC+1];
  assign s6_rnd_w  = 32'((33'(s6_v_w) + (33'd1 << (TAB_FRAC - FRAC_BITS - 1)))
                         >> (TAB_FRAC - FRAC_BITS));
  assign s7_g_w    = qmul(amp_i, s6_e_q);
  assign s7_p_w    = qmul(s6_ab_q, s6_d_q);
  assign s7_abe_w  = qmul(s6_ab_q, s6_e_q);
  assign s8_q_w    = qmul(s7_p_q, s7_e_q);
  assign s8_w_w    = qmul(s7_abe_q, s7_t_q);
  assign s9_d1_w   = sat32(-(64'(s8_q_q) <<< 1));
  assign s9_d2_w   = sat32((64'(s8_w_q) <<< 2) - (64'(s8_abe_q) <<< 1));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_d_q   <= sat32(64'(x_i) - 64'(cen_i));
      s1_ab_q  <= qmul(amp_i, wid_i);

      s2_d_q   <= s1_d_q.v;
      s2_dd_q  <= s2_dd_w.v;
      s2_ab_q  <= s1_ab_q.v;
      s2_fb_q  <= s1_d_q.f | s2_dd_w.f;
      s2_fab_q <= s1_ab_q.f;

      s3_d_q   <= s2_d_q;
      s3_t_q   <= s3_t_w.v;
      s3_ab_q  <= s2_ab_q;
      s3_fb_q  <= s2_fb_q | s3_t_w.f;
      s3_fab_q <= s2_fab_q;

      s4_idx_q <= s4_p_w[DEN_W +: IDX_W];
      s4_fr_q  <= s4_p_w[DEN_W-1:0];
      s4_neg_q <= s3_t_q[31];
      s4_big_q <= !s3_t_q[31] && (s3_t_q[30:0] >= 31'(EXP_SPAN << FRAC_BITS));
      s4_fb_q  <= s3_fb_q | s3_t_q[31];
      s4_fab_q <= s3_fab_q;
      s4_d_q   <= s3_d_q;
      s4_t_q   <= s3_t_q;
      s4_ab_q  <= s3_ab_q;

      s5_t0_q  <= EXP_TAB[s4_idx_q];
      s5_t1_q  <= EXP_TAB[s4_idx_q + IDX_W'(1)];
      s5_fr_q  <= s4_fr_q;
      s5_neg_q <= s4_neg_q;
      s5_big_q <= s4_big_q;
      s5_fb_q  <= s4_fb_q;
      s5_fab_q <= s4_fab_q;
      s5_d_q   <= s4_d_q;
      s5_t_q   <= s4_t_q;
      s5_ab_q  <= s4_ab_q;

      if (s5_neg_q) begin
        s6_e_q <= 32'sd1 <<< FRAC_BITS;
      end else if (s5_big_q) begin
        s6_e_q <= 32'sd0;
      end else begin
        s6_e_q <= s6_rnd_w;
      end
      s6_d_q   <= s5_d_q;
      s6_t_q   <= s5_t_q;
      s6_ab_q  <= s5_ab_q;
      s6_fb_q  <= s5_fb_q;
      s6_fab_q <= s5_fab_q;

      s7_g_q   <= s7_g_w.v;
      s7_p_q   <= s7_p_w.v;
      s7_abe_q <= s7_abe_w.v;
      s7_e_q   <= s6_e_q;
      s7_t_q   <= s6_t_q;
      s7_fg_q  <= s6_fb_q | s7_g_w.f;
      s7_f1_q  <= s6_fb_q | s6_fab_q | s7_p_w.f;
      s7_f2_q  <= s6_fb_q | s6_fab_q | s7_abe_w.f;

      s8_g_q   <= s7_g_q;
      s8_q_q   <= s8_q_w.v;
      s8_w_q   <= s8_w_w.v;
      s8_abe_q <= s7_abe_q;
      s8_fg_q  <= s7_fg_q;
      s8_f1_q  <= s7_f1_q | s8_q_w.f;
      s8_f2_q  <= s7_f2_q | s8_w_w.f;

      res_o.g  <= s8_g_q;
      res_o.fg <= s8_fg_q;
      res_o.d1 <= s9_d1_w.v;
      res_o.f1 <= s8_f1_q | s9_d1_w.f;
      res_o.d2 <= s9_d2_w.v;
      res_o.f2 <= s8_f2_q | s9_d2_w.f;
    end
  end

endmodule
`default_nettype wire

>>> design/double_gaussian_evaluator_top.sv
// Top level of the two-peak Gaussian model evaluator.
// Each input beat carries a Q16.16 position and an operation code and yields one result beat
// with the full model value, one peak, or the first or second derivative, saturated with a
// flag. The pipeline takes one beat per cycle while the output is not stalled; its depth is
// set by the chain of dependent multiplies and the exp table lookup. The whole pipe advances
// whenever the output register is empty or being taken. Configuration registers must be
// written by the user through the plain write port while no beat is in flight (not enforced).
`default_nettype none
module double_gaussian_evaluator_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  dge_in_if.sink           in_i,
  dge_out_if.source        out_o,
  input  wire logic        cfg_we_i,
  input  wire logic [2:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_data_i
);
  import dge_pkg::*;

  logic signed [31:0] amp1_q, wid1_q, cen1_q, amp2_q, wid2_q, cen2_q, offs_q;
  logic [PEAK_LAT-1:0] vld_q;
  logic [2:0] op_q [PEAK_LAT];
  logic adv;
  peak_res_t p1, p2;
  qres_t sum_full, sum_d1, sum_d2;
  logic out_valid_q;
  logic signed [31:0] res_d, res_q;
  logic sat_d, sat_q;

  assign adv = !out_valid_q || out_o.ready;
  assign in_i.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp1_q <= '0;
      wid1_q <= '0;
      cen1_q <= '0;
      amp2_q <= '0;
      wid2_q <= '0;
      cen2_q <= '0;
      offs_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_AMP1: amp1_q <= cfg_data_i;
        REG_WID1: wid1_q <= cfg_data_i;
        REG_CEN1: cen1_q <= cfg_data_i;
        REG_AMP2: amp2_q <= cfg_data_i;
        REG_WID2: wid2_q <= cfg_data_i;
        REG_CEN2: cen2_q <= cfg_data_i;
        REG_OFFS: offs_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  dge_peak u_peak1 (
    .clk_i (clk_i), .en_i (adv), .x_i (in_i.sample_position),
    .amp_i (amp1_q), .wid_i (wid1_q), .cen_i (cen1_q), .res_o (p1)
  );

  dge_peak u_peak2 (
    .clk_i (clk_i), .en_i (adv), .x_i (in_i.sample_position),
    .amp_i (amp2_q), .wid_i (wid2_q), .cen_i (cen2_q), .res_o (p2)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[PEAK_LAT-2:0], in_i.valid};
      out_valid_q <= vld_q[PEAK_LAT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      op_q[0] <= in_i.operation;
      for (int i = 1; i < PEAK_LAT; i++) begin
        op_q[i] <= op_q[i-1];
      end
      res_q <= res_d;
      sat_q <= sat_d;
    end
  end

  assign sum_full = sat32(64'(p1.g) + 64'(p2.g) + 64'(offs_q));
  assign sum_d1   = sat32(64'(p1.d1) + 64'(p2.d1));
  assign sum_d2   = sat32(64'(p1.d2) + 64'(p2.d2));

  always_comb begin
    unique case (op_q[PEAK_LAT-1])
      OP_FULL: begin
        res_d = sum_full.v;
        sat_d = p1.fg | p2.fg | sum_full.f;
      end
      OP_PEAK1: begin
        res_d = p1.g;
        sat_d = p1.fg;
      end
      OP_PEAK2: begin
        res_d = p2.g;
        sat_d = p2.fg;
      end
      OP_DERIV1: begin
        res_d = sum_d1.v;
        sat_d = p1.f1 | p2.f1 | sum_d1.f;
      end
      OP_DERIV2: begin
        res_d = sum_d2.v;
        sat_d = p1.f2 | p2.f2 | sum_d2.f;
      end
      default: begin
        res_d = '0;
        sat_d = 1'b0;
      end
    endcase
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.result_value = res_q;
  assign out_o.saturated    = sat_q;

endmodule
`default_nettype wire

>>> design/dge_checker.sv
// Port-level checker for the evaluator, bound to the top level.
`default_nettype none
module dge_port_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [31:0] out_value_i,
  input wire logic        out_sat_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_value_i) && $stable(out_sat_i))
    else $error("Output beat changed while stalled.");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("Input taken while the output stalls.");

  a_empty_takes_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("Input refused with an empty output register.");

  a_no_result_after_reset: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_i)
    else $error("Result beat right after reset.");

endmodule

bind double_gaussian_evaluator_top dge_port_checker u_dge_port_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_value_i (out_o.result_value),
  .out_sat_i   (out_o.saturated)
);
`default_nettype wire
